FILE: src/ceq_pkg.sv
// Shared types and constants for the coalescing event queue.
// Used by the controller, datapath, top level and port checker.
package ceq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int TYPE_W    = 4;
  localparam int RESERVE_W = 6;
  localparam int REPEAT_W  = 32;
  localparam int NUM_BG    = 3;   // packet, bridge event, tick
  localparam int BG_IDX_W  = $clog2(NUM_BG);

  localparam logic [RESERVE_W-1:0] RESERVE_RESET = RESERVE_W'(4);
  localparam logic [TYPE_W-1:0]    TICK_TYPE     = TYPE_W'(2);
  localparam logic [REPEAT_W-1:0]  REPEAT_MAX    = '1;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ceq_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request, read head slot
    logic exec;     // update queue, load result register
  } ceq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free; // result register empty or being drained this cycle
  } ceq_status_t;

endpackage

FILE: src/ceq_ctrl.sv
// Sequencer for the coalescing event queue: capture a request, then execute it.
// Depends on ceq_pkg.
module ceq_ctrl
  import ceq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ceq_status_t status,
  output ceq_cmd_t    cmd
);

  ceq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: src/ceq_datapath.sv
// Queue storage, pointers, coalescing state and result register.
// Depends on ceq_pkg; driven by ceq_ctrl commands.
module ceq_datapath
  import ceq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int IDX_W  = $clog2(QUEUE_DEPTH),
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ceq_cmd_t                cmd,
  output ceq_status_t             status,
  input  logic                    cfg_valid,
  input  logic [RESERVE_W-1:0]    cfg_data,
  input  logic                    kind,
  input  logic [TYPE_W-1:0]       event_type,
  input  logic [PAYLOAD_BITS-1:0] event_payload,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    success,
  output logic                    merged,
  output logic [TYPE_W-1:0]       out_type,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic [REPEAT_W-1:0]     out_repeat,
  output logic [FILL_W-1:0]       fill_level
);

  localparam int SUM_W  = ((FILL_W > RESERVE_W) ? FILL_W : RESERVE_W) + 1;
  localparam int TAIL_W = IDX_W + 1;

  logic [TYPE_W-1:0]       type_mem    [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] payload_mem [QUEUE_DEPTH];

  logic [RESERVE_W-1:0]    reserve;
  logic [IDX_W-1:0]        head, head_next;
  logic [FILL_W-1:0]       occupancy, occupancy_next;
  // Each background type is queued at most once: a present bit per type,
  // and the tick's repeat count lives in a single register.
  logic [NUM_BG-1:0]       present, present_next;
  logic [REPEAT_W-1:0]     tick_repeat, tick_repeat_next;

  logic                    op_kind;
  logic [TYPE_W-1:0]       op_type;
  logic [PAYLOAD_BITS-1:0] op_payload;
  logic [TYPE_W-1:0]       rd_type;
  logic [PAYLOAD_BITS-1:0] rd_payload;

  logic                    op_bg, op_tick, rd_bg;
  logic [BG_IDX_W-1:0]     op_bg_idx, rd_bg_idx;
  logic [SUM_W-1:0]        room_sum;
  logic                    bg_room, ctl_room;
  logic [TAIL_W-1:0]       tail_sum;
  logic [IDX_W-1:0]        tail;
  logic                    wr_en;

  logic                    res_success, res_merged;
  logic [TYPE_W-1:0]       res_type;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic [REPEAT_W-1:0]     res_repeat;

  assign status.out_free = !out_valid || out_ready;

  assign op_bg     = op_type <= TICK_TYPE;
  assign op_tick   = op_type == TICK_TYPE;
  assign op_bg_idx = op_type[BG_IDX_W-1:0];
  assign rd_bg     = rd_type <= TICK_TYPE;
  assign rd_bg_idx = rd_type[BG_IDX_W-1:0];

  // background room: occupancy + reserve < depth (no wrap on large reserve)
  assign room_sum = SUM_W'(occupancy) + SUM_W'(reserve);
  assign bg_room  = room_sum < SUM_W'(QUEUE_DEPTH);
  assign ctl_room = occupancy < FILL_W'(QUEUE_DEPTH);

  // tail is only used when occupancy < depth, so the sum stays below 2*depth
  assign tail_sum = TAIL_W'(head) + TAIL_W'(occupancy);
  assign tail     = (tail_sum >= TAIL_W'(QUEUE_DEPTH)) ?
                    IDX_W'(tail_sum - TAIL_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

  always_comb begin
    res_success      = 1'b0;
    res_merged       = 1'b0;
    res_type         = '0;
    res_payload      = '0;
    res_repeat       = '0;
    wr_en            = 1'b0;
    head_next        = head;
    occupancy_next   = occupancy;
    present_next     = present;
    tick_repeat_next = tick_repeat;
    if (cmd.exec) begin
      if (op_kind == KIND_PUSH) begin
        if (op_bg && present[op_bg_idx]) begin
          res_success = 1'b1;
          res_merged  = 1'b1;
          if (op_tick && tick_repeat != REPEAT_MAX) begin
            tick_repeat_next = tick_repeat + REPEAT_W'(1);
          end
        end else if (op_bg ? bg_room : ctl_room) begin
          res_success    = 1'b1;
          wr_en          = 1'b1;
          occupancy_next = occupancy + FILL_W'(1);
          if (op_bg) present_next[op_bg_idx] = 1'b1;
          if (op_tick) tick_repeat_next = REPEAT_W'(1);
        end
      end else if (occupancy != '0) begin
        res_success    = 1'b1;
        res_type       = rd_type;
        res_payload    = rd_payload;
        res_repeat     = (rd_type == TICK_TYPE) ? tick_repeat : REPEAT_W'(1);
        occupancy_next = occupancy - FILL_W'(1);
        head_next      = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
        if (rd_bg) present_next[rd_bg_idx] = 1'b0;
      end
    end
  end

  // storage: write at tail, registered read of the head slot at capture
  always_ff @(posedge clk) begin
    if (wr_en) begin
      type_mem[tail]    <= op_type;
      payload_mem[tail] <= op_payload;
    end
    if (cmd.capture) begin
      rd_type    <= type_mem[head];
      rd_payload <= payload_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind    <= kind;
      op_type    <= event_type;
      op_payload <= event_payload;
    end
    if (cmd.exec) begin
      success     <= res_success;
      merged      <= res_merged;
      out_type    <= res_type;
      out_payload <= res_payload;
      out_repeat  <= res_repeat;
      fill_level  <= occupancy_next;
    end
    tick_repeat <= tick_repeat_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserve   <= RESERVE_RESET;
      head      <= '0;
      occupancy <= '0;
      present   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) reserve <= cfg_data;
      head      <= head_next;
      occupancy <= occupancy_next;
      present   <= present_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/coalescing_event_queue.sv
// Coalescing event queue: ring FIFO of typed events, push or pop per request.
// The result register loads in the execute step that follows the accepted
// input beat (capture/head read, then execute); no new request is accepted until execute is done.
// A full result register holds off the execute step until its beat is taken.
// Reset (rst, synchronous): queue empty, head at slot 0, reserve 4; slot
// storage is not cleared.
module coalescing_event_queue
  import ceq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [RESERVE_W-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic [TYPE_W-1:0]       event_type,
  input  logic [PAYLOAD_BITS-1:0] event_payload,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    success,
  output logic                    merged,
  output logic [TYPE_W-1:0]       out_type,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic [REPEAT_W-1:0]     out_repeat,
  output logic [FILL_W-1:0]       fill_level
);

  ceq_cmd_t    cmd;
  ceq_status_t status;

  assign cfg_ready = 1'b1;

  ceq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ceq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .event_type    (event_type),
    .event_payload (event_payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .success       (success),
    .merged        (merged),
    .out_type      (out_type),
    .out_payload   (out_payload),
    .out_repeat    (out_repeat),
    .fill_level    (fill_level)
  );

endmodule

FILE: src/ceq_checker.sv
// Port-level checks for coalescing_event_queue, attached by bind.
// Depends on ceq_pkg.
module ceq_checker
  import ceq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    success,
  input logic                    merged,
  input logic [TYPE_W-1:0]       out_type,
  input logic [PAYLOAD_BITS-1:0] out_payload,
  input logic [REPEAT_W-1:0]     out_repeat,
  input logic [FILL_W-1:0]       fill_level
);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_level <= FILL_W'(QUEUE_DEPTH))
    else $error("fill level above queue depth");

  a_merge_success: assert property (@(posedge clk) disable iff (rst)
    out_valid && merged |-> success && out_repeat == '0)
    else $error("merge beat without success or with pop data");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !success |-> !merged && out_type == '0 && out_payload == '0 &&
                              out_repeat == '0)
    else $error("failed beat carries data");

  a_repeat_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_repeat > REPEAT_W'(1) |-> out_type == TICK_TYPE)
    else $error("repeat count above one on a non-tick entry");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(success) && $stable(out_payload) &&
                                $stable(fill_level))
    else $error("result beat changed while stalled");

endmodule

bind coalescing_event_queue ceq_checker #(
  .QUEUE_DEPTH  (QUEUE_DEPTH),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_ceq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .success     (success),
  .merged      (merged),
  .out_type    (out_type),
  .out_payload (out_payload),
  .out_repeat  (out_repeat),
  .fill_level  (fill_level)
);

FILE: test/ceq_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the coalescing event queue: follows config and request
// beats, predicts every result and compares it with the output beats.
// Depends on ceq_pkg only.
module ceq_result_checker
  import ceq_pkg::*;
#(
  parameter int DEPTH  = QUEUE_DEPTH_DEF,
  parameter int PAY_W  = PAYLOAD_BITS_DEF,
  localparam int FILL_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [RESERVE_W-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 kind,
  input  logic [TYPE_W-1:0]    event_type,
  input  logic [PAY_W-1:0]     event_payload,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 success,
  input  logic                 merged,
  input  logic [TYPE_W-1:0]    out_type,
  input  logic [PAY_W-1:0]     out_payload,
  input  logic [REPEAT_W-1:0]  out_repeat,
  input  logic [FILL_W-1:0]    fill_level,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic                success;
    logic                merged;
    logic [TYPE_W-1:0]   etype;
    logic [PAY_W-1:0]    payload;
    logic [REPEAT_W-1:0] count;
    logic [FILL_W-1:0]   fill;
  } queue_outcome_t;

  // shadow copy of the queue
  logic [TYPE_W-1:0]    slot_type    [DEPTH];
  logic [PAY_W-1:0]     slot_payload [DEPTH];
  logic [REPEAT_W-1:0]  slot_count   [DEPTH];
  int                   head      = 0;
  int                   occupancy = 0;
  logic [RESERVE_W-1:0] reserve   = RESERVE_RESET;

  queue_outcome_t awaited_results[$];
  int             errors = 0;

  assign fail_count = errors;

  function automatic queue_outcome_t apply_request(logic k, logic [TYPE_W-1:0] t,
                                                   logic [PAY_W-1:0] p);
    queue_outcome_t r;
    int limit;
    int hit;
    int slot;
    r = '0;
    if (k == KIND_PUSH) begin
      limit = DEPTH;
      hit = -1;
      if (t <= TICK_TYPE) begin
        // background: merge into the oldest queued entry of this type
        for (int i = 0; i < occupancy; i++) begin
          slot = (head + i) % DEPTH;
          if (hit < 0 && slot_type[slot] == t) hit = slot;
        end
        if (hit < 0) limit = (int'(reserve) >= DEPTH) ? 0 : DEPTH - int'(reserve);
      end
      if (hit >= 0) begin
        if (t == TICK_TYPE && slot_count[hit] != REPEAT_MAX)
          slot_count[hit] = slot_count[hit] + REPEAT_W'(1);
        r.success = 1'b1;
        r.merged  = 1'b1;
      end else if (occupancy < limit) begin
        slot = (head + occupancy) % DEPTH;
        slot_type[slot]    = t;
        slot_payload[slot] = p;
        slot_count[slot]   = REPEAT_W'(1);
        occupancy++;
        r.success = 1'b1;
      end
    end else if (occupancy > 0) begin
      r.etype   = slot_type[head];
      r.payload = slot_payload[head];
      r.count   = slot_count[head];
      r.success = 1'b1;
      head = (head + 1) % DEPTH;
      occupancy--;
    end
    r.fill = FILL_W'(occupancy);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    queue_outcome_t want;
    if (rst) begin
      head = 0;
      occupancy = 0;
      reserve = RESERVE_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) reserve = cfg_data;
      if (in_valid && in_ready)
        awaited_results.push_back(apply_request(kind, event_type, event_payload));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing pending, expected none, actual %b/%b fill %0d",
                   $time, success, merged, fill_level);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("success",     64'(want.success), 64'(success));
          check_field("merged",      64'(want.merged),  64'(merged));
          check_field("out_type",    64'(want.etype),   64'(out_type));
          check_field("out_payload", 64'(want.payload), 64'(out_payload));
          check_field("out_repeat",  64'(want.count),   64'(out_repeat));
          check_field("fill_level",  64'(want.fill),    64'(fill_level));
        end
      end
    end
    pending <= awaited_results.size();
  end

endmodule

FILE: test/tb_coalescing_event_queue.sv
`timescale 1ns / 100ps
// Testbench top for coalescing_event_queue: drives request, config and
// output-ready traffic; ceq_result_checker does the prediction and compare.
// Depends on ceq_pkg, the RTL and ceq_result_checker.
module tb_coalescing_event_queue;
  import ceq_pkg::*;

  localparam int FILL_W        = $clog2(QUEUE_DEPTH_DEF + 1);
  localparam int STALL_LIMIT   = 2000;
  localparam logic [TYPE_W-1:0] EV_PACKET     = TYPE_W'(0);
  localparam logic [TYPE_W-1:0] EV_BRIDGE     = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] EV_CTRL_FIRST = TYPE_W'(3);
  localparam logic [TYPE_W-1:0] EV_CTRL_LAST  = TYPE_W'(15);

  logic                        clk           = 1'b0;
  logic                        rst           = 1'b1;
  logic                        cfg_valid     = 1'b0;
  logic [RESERVE_W-1:0]        cfg_data      = '0;
  logic                        in_valid      = 1'b0;
  logic                        kind          = KIND_PUSH;
  logic [TYPE_W-1:0]           event_type    = '0;
  logic [PAYLOAD_BITS_DEF-1:0] event_payload = '0;
  logic                        out_ready     = 1'b0;

  logic                        cfg_ready;
  logic                        in_ready;
  logic                        out_valid;
  logic                        success;
  logic                        merged;
  logic [TYPE_W-1:0]           out_type;
  logic [PAYLOAD_BITS_DEF-1:0] out_payload;
  logic [REPEAT_W-1:0]         out_repeat;
  logic [FILL_W-1:0]           fill_level;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit calm = 1'b0;
  int phase_reserve[6] = '{32, 63, 28, 31, 0, 4};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  coalescing_event_queue dut (.*);
  ceq_result_checker     u_result_checker (.*);

  // output-side stalls in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // valid is left high after the beat; the next call drives the next item
  task automatic issue(logic k, logic [TYPE_W-1:0] t, logic [PAYLOAD_BITS_DEF-1:0] p);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    event_type    <= t;
    event_payload <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pop_oldest();
    issue(KIND_POP, TYPE_W'($urandom), $urandom);
  endtask

  task automatic push_control();
    issue(KIND_PUSH, TYPE_W'($urandom_range(EV_CTRL_FIRST, EV_CTRL_LAST)), $urandom);
  endtask

  // hold requests until every result beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reserve(logic [RESERVE_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(int push_pct);
    logic k;
    logic [TYPE_W-1:0] t;
    k = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
    if ($urandom_range(0, 99) < 55)
      t = TYPE_W'($urandom_range(EV_PACKET, TICK_TYPE));
    else
      t = TYPE_W'($urandom_range(EV_CTRL_FIRST, EV_CTRL_LAST));
    issue(k, t, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, merges, tick counting, control types, drain
    issue(KIND_POP, EV_CTRL_LAST, '1);
    issue(KIND_PUSH, EV_PACKET, '0);
    issue(KIND_PUSH, EV_PACKET, '1);           // merged, payload kept
    issue(KIND_PUSH, TICK_TYPE, 32'hA5A5A5A5);
    issue(KIND_PUSH, TICK_TYPE, 32'h5A5A5A5A);
    issue(KIND_PUSH, TICK_TYPE, '0);           // tick count 3
    issue(KIND_PUSH, EV_BRIDGE, '1);
    issue(KIND_PUSH, EV_CTRL_FIRST, 32'h0000FFFF);
    issue(KIND_PUSH, EV_CTRL_LAST, '1);
    issue(KIND_PUSH, EV_CTRL_LAST, 32'hFFFF0000);  // control types never merge
    repeat (6) pop_oldest();
    issue(KIND_POP, EV_PACKET, '0);

    // fill to the top with no reserve
    write_reserve(RESERVE_W'(0));
    repeat (QUEUE_DEPTH_DEF + 1) push_control();  // last one hits a full queue
    issue(KIND_PUSH, EV_BRIDGE, $urandom);        // full, type not queued
    pop_oldest();
    issue(KIND_PUSH, EV_BRIDGE, $urandom);        // takes the last slot
    issue(KIND_PUSH, EV_BRIDGE, $urandom);        // merges while full
    write_reserve(RESERVE_W'(5));
    repeat (2) pop_oldest();
    issue(KIND_PUSH, EV_PACKET, $urandom);        // above the reserve line
    issue(KIND_PUSH, EV_BRIDGE, $urandom);        // merge ignores the reserve
    repeat (QUEUE_DEPTH_DEF) pop_oldest();

    phase_reserve[4] = int'($urandom_range(0, 63));
    foreach (phase_reserve[ph]) begin
      write_reserve(RESERVE_W'(phase_reserve[ph]));
      calm = (ph == $size(phase_reserve) - 1);
      repeat (40) random_item(85);
      repeat (25) random_item(30);
    end

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
